[rtl/suffixient_set_scan_core_defines.svh]
// assertion macros shared by the checker
`ifndef SUFFIXIENT_SET_SCAN_CORE_DEFINES_SVH
`define SUFFIXIENT_SET_SCAN_CORE_DEFINES_SVH

// same-cycle implication, masked during reset
`define SSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define SSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// state right after a reset cycle
`define SSS_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

[rtl/sss_pkg.sv]
package sss_pkg;

  // fixed field widths
  localparam int FIELD_W  = 40;
  localparam int SYM_W    = 6;
  localparam int SYM_SPAN = 64;
  localparam int LEN_W    = FIELD_W + 1;

  // candidate length of an empty entry
  localparam logic signed [LEN_W-1:0] LEN_NONE = '1;
  // run minimum after a boundary
  localparam logic [FIELD_W-1:0] RUN_MIN_MAX = '1;

  // per-pass control handed to the head cell
  typedef struct packed {
    logic             end_pass;
    logic             gt_bound;
    logic [SYM_W-1:0] prev_sym;
    logic [SYM_W-1:0] cur_sym;
  } pass_ctl_t;

endpackage

[rtl/sss_cell.sv]
module sss_cell import sss_pkg::*; #(
  parameter int PW = 40
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    shift,
  input  logic signed [LEN_W-1:0] len_in,
  input  logic [PW-1:0]           pos_in,
  input  logic                    act_in,
  output logic signed [LEN_W-1:0] len,
  output logic [PW-1:0]           pos,
  output logic                    act
);

  // one candidate record, moved one place along the ring per scan step
  always_ff @(posedge clk) begin
    if (rst) begin
      len <= LEN_NONE;
      pos <= '0;
      act <= 1'b0;
    end else if (shift) begin
      len <= len_in;
      pos <= pos_in;
      act <= act_in;
    end
  end

endmodule

[rtl/sss_head.sv]
module sss_head import sss_pkg::*; #(
  parameter int PW    = 40,
  parameter int IDX_W = 6
) (
  input  pass_ctl_t               ctl,
  input  logic [IDX_W-1:0]        idx,
  input  logic signed [LEN_W-1:0] bound,
  input  logic signed [LEN_W-1:0] lcp_len,
  input  logic [PW-1:0]           pos_prev,
  input  logic [PW-1:0]           pos_cur,
  input  logic signed [LEN_W-1:0] len_in,
  input  logic [PW-1:0]           pos_in,
  input  logic                    act_in,
  output logic signed [LEN_W-1:0] len_out,
  output logic [PW-1:0]           pos_out,
  output logic                    act_out,
  output logic                    emit
);

  logic [SYM_W-1:0] sym;
  logic             retired;
  logic             hit_prev;
  logic             hit_cur;
  logic             grows;

  assign sym      = SYM_W'(idx);
  // symbol zero is never retired
  assign retired  = (idx != '0) && (bound < len_in);
  assign emit     = retired && act_in;
  assign hit_prev = (sym == ctl.prev_sym);
  assign hit_cur  = (sym == ctl.cur_sym);
  // install test against the length left after retiring
  assign grows    = retired ? ctl.gt_bound : (lcp_len > len_in);

  // on an end pass clear the record; else retire, then install for the two boundary symbols
  always_comb begin
    len_out = len_in;
    pos_out = pos_in;
    act_out = act_in;
    if (ctl.end_pass) begin
      len_out = LEN_NONE;
      pos_out = '0;
      act_out = 1'b0;
    end else begin
      if (retired) begin
        len_out = bound;
        pos_out = '0;
        act_out = 1'b0;
      end
      if ((hit_prev || hit_cur) && grows) begin
        len_out = lcp_len;
        pos_out = hit_prev ? pos_prev : pos_cur;
        act_out = 1'b1;
      end
    end
  end

endmodule

[rtl/suffixient_set_scan_core.sv]
// a triple inside a run passes through accept and prepare (IDLE, PREP) and gives no result.
// a run boundary or end item adds one ring scan over all ALPHABET cells, then a drain state;
// the scan pauses while an emitted member waits on the output register.
// throughput: one item at a time, set by the rotation of the candidate ring past the head.
// reset (rst, synchronous): candidates empty, counters cleared, runs at one,
// text_length back to 1; no clearing pass is needed.
module suffixient_set_scan_core import sss_pkg::*; #(
  parameter int ALPHABET = 64,
  parameter int POS_BITS = 40
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [FIELD_W-1:0] cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [SYM_W-1:0]   bwt_sym,
  input  logic [FIELD_W-1:0] lcp,
  input  logic [FIELD_W-1:0] sa_pos,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               result_kind,
  output logic [FIELD_W-1:0] position,
  output logic [FIELD_W-1:0] set_size,
  output logic [FIELD_W-1:0] run_count,
  output logic               last
);

  localparam int PW    = (POS_BITS < FIELD_W) ? POS_BITS : FIELD_W;
  localparam int IDX_W = $clog2(ALPHABET);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ALPHABET - 1);

  typedef enum logic [2:0] {IDLE, PREP, SCAN, DRAIN, SUMMARY} state_t;

  state_t                  state;
  logic [IDX_W-1:0]        idx;
  logic [FIELD_W-1:0]      text_length;

  // accepted item
  logic                    it_kind;
  logic [SYM_W-1:0]        it_sym;
  logic [FIELD_W-1:0]      it_lcp;
  logic [FIELD_W-1:0]      it_sa;

  // stream state
  logic                    started;
  logic [FIELD_W-1:0]      run_min;
  logic [SYM_W-1:0]        prev_sym;
  logic [FIELD_W-1:0]      prev_sa;
  logic [FIELD_W-1:0]      member_count;
  logic [FIELD_W-1:0]      runs_seen;

  // operands of the current scan
  pass_ctl_t               pass_ctl;
  logic signed [LEN_W-1:0] pass_bound;
  logic signed [LEN_W-1:0] pass_lcp;
  logic [PW-1:0]           pass_pos_prev;
  logic [PW-1:0]           pass_pos_cur;

  // member waiting to learn whether it is the last one
  logic                    held_v;
  logic [PW-1:0]           held_pos;
  logic [FIELD_W-1:0]      held_set;
  logic [FIELD_W-1:0]      held_run;

  // output register
  logic                    out_kind;
  logic [PW-1:0]           out_pos;
  logic [FIELD_W-1:0]      out_set;
  logic [FIELD_W-1:0]      out_run;
  logic                    out_last;

  logic [SYM_W-1:0]        fold_tab [SYM_SPAN];
  logic [FIELD_W-1:0]      run_min_new;
  logic [PW-1:0]           pos_prev_c;
  logic [PW-1:0]           pos_cur_c;
  logic                    out_free;
  logic                    out_load;
  logic                    scan_step;

  logic signed [LEN_W-1:0] ring_len [ALPHABET];
  logic [PW-1:0]           ring_pos [ALPHABET];
  logic                    ring_act [ALPHABET];
  logic signed [LEN_W-1:0] head_len;
  logic [PW-1:0]           head_pos;
  logic                    head_act;
  logic                    head_emit;

  // symbol folding table, built at elaboration
  for (genvar g = 0; g < SYM_SPAN; g++) begin : g_fold
    assign fold_tab[g] = SYM_W'(g % ALPHABET);
  end

  // prepare-stage arithmetic
  assign run_min_new = (it_lcp < run_min) ? it_lcp : run_min;
  assign pos_prev_c  = (prev_sa > text_length) ? '0 : PW'(text_length - prev_sa);
  assign pos_cur_c   = (it_sa > text_length) ? '0 : PW'(text_length - it_sa);

  // handshakes
  assign cfg_ready = 1'b1;
  assign in_ready  = (state == IDLE);
  assign out_free  = !out_valid || out_ready;
  assign scan_step = (state == SCAN) && (!head_emit || !held_v || out_free);

  // output register loads: a held member pushed out, the drained member, the summary
  assign out_load = (scan_step && head_emit && held_v) ||
                    ((state == DRAIN) && held_v && out_free) ||
                    ((state == SUMMARY) && out_free);

  assign result_kind = out_kind;
  assign position    = FIELD_W'(out_pos);
  assign set_size    = out_set;
  assign run_count   = out_run;
  assign last        = out_last;

  // head cell: retire and install on the record passing by
  sss_head #(
    .PW    (PW),
    .IDX_W (IDX_W)
  ) u_head (
    .ctl      (pass_ctl),
    .idx      (idx),
    .bound    (pass_bound),
    .lcp_len  (pass_lcp),
    .pos_prev (pass_pos_prev),
    .pos_cur  (pass_pos_cur),
    .len_in   (ring_len[0]),
    .pos_in   (ring_pos[0]),
    .act_in   (ring_act[0]),
    .len_out  (head_len),
    .pos_out  (head_pos),
    .act_out  (head_act),
    .emit     (head_emit)
  );

  // candidate ring: cell 0 feeds the head, the head feeds the tail
  for (genvar c = 0; c < ALPHABET; c++) begin : g_ring
    if (c == ALPHABET - 1) begin : g_tail
      sss_cell #(.PW(PW)) u_cell (
        .clk    (clk),
        .rst    (rst),
        .shift  (scan_step),
        .len_in (head_len),
        .pos_in (head_pos),
        .act_in (head_act),
        .len    (ring_len[c]),
        .pos    (ring_pos[c]),
        .act    (ring_act[c])
      );
    end else begin : g_body
      sss_cell #(.PW(PW)) u_cell (
        .clk    (clk),
        .rst    (rst),
        .shift  (scan_step),
        .len_in (ring_len[c+1]),
        .pos_in (ring_pos[c+1]),
        .act_in (ring_act[c+1]),
        .len    (ring_len[c]),
        .pos    (ring_pos[c]),
        .act    (ring_act[c])
      );
    end
  end

  // sequencer, stream state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      idx          <= '0;
      text_length  <= FIELD_W'(1);
      started      <= 1'b0;
      run_min      <= RUN_MIN_MAX;
      prev_sym     <= '0;
      prev_sa      <= '0;
      member_count <= '0;
      runs_seen    <= FIELD_W'(1);
      held_v       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        text_length <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_valid) begin
            it_kind <= kind;
            it_sym  <= fold_tab[bwt_sym];
            it_lcp  <= lcp;
            it_sa   <= sa_pos;
            state   <= PREP;
          end
        end
        PREP: begin
          pass_ctl.prev_sym <= prev_sym;
          pass_ctl.cur_sym  <= it_sym;
          pass_ctl.gt_bound <= (it_lcp > run_min);
          pass_lcp          <= $signed({1'b0, it_lcp});
          pass_pos_prev     <= pos_prev_c;
          pass_pos_cur      <= pos_cur_c;
          if (it_kind) begin
            // end of stream: flush every candidate
            pass_ctl.end_pass <= 1'b1;
            pass_bound        <= LEN_NONE;
            state             <= SCAN;
          end else if (!started) begin
            started  <= 1'b1;
            prev_sym <= it_sym;
            prev_sa  <= it_sa;
            state    <= IDLE;
          end else begin
            prev_sym <= it_sym;
            prev_sa  <= it_sa;
            if (it_sym != prev_sym) begin
              // run boundary
              pass_ctl.end_pass <= 1'b0;
              pass_bound        <= $signed({1'b0, run_min_new});
              run_min           <= RUN_MIN_MAX;
              state             <= SCAN;
            end else begin
              run_min <= run_min_new;
              state   <= IDLE;
            end
          end
        end
        SCAN: begin
          if (scan_step) begin
            if (head_emit) begin
              if (held_v) begin
                out_kind  <= 1'b0;
                out_pos   <= held_pos;
                out_set   <= held_set;
                out_run   <= held_run;
                out_last  <= 1'b0;
              end
              held_v       <= 1'b1;
              held_pos     <= ring_pos[0];
              held_set     <= member_count + FIELD_W'(1);
              held_run     <= runs_seen;
              member_count <= member_count + FIELD_W'(1);
            end
            if (idx == IDX_LAST) begin
              idx   <= '0;
              state <= DRAIN;
              if (!pass_ctl.end_pass) begin
                runs_seen <= runs_seen + FIELD_W'(1);
              end
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        DRAIN: begin
          if (!held_v) begin
            state <= pass_ctl.end_pass ? SUMMARY : IDLE;
          end else if (out_free) begin
            out_kind  <= 1'b0;
            out_pos   <= held_pos;
            out_set   <= held_set;
            out_run   <= held_run;
            out_last  <= !pass_ctl.end_pass;
            held_v    <= 1'b0;
            state     <= pass_ctl.end_pass ? SUMMARY : IDLE;
          end
        end
        SUMMARY: begin
          if (out_free) begin
            out_kind     <= 1'b1;
            out_pos      <= '0;
            out_set      <= member_count;
            out_run      <= runs_seen;
            out_last     <= 1'b1;
            started      <= 1'b0;
            run_min      <= RUN_MIN_MAX;
            prev_sym     <= '0;
            prev_sa      <= '0;
            member_count <= '0;
            runs_seen    <= FIELD_W'(1);
            state        <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/sss_checker.sv]
`include "suffixient_set_scan_core_defines.svh"

module sss_checker import sss_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               result_kind,
  input logic [FIELD_W-1:0] position,
  input logic               last
);

  // a stalled result keeps its payload
  `SSS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(position) && $stable(last), "stalled result changed")

  // the summary closes the results of an end item and carries no position
  `SSS_ASSERT_IMP(a_summary_last, out_valid && result_kind, last && (position == '0), "bad summary")

  // one item at a time: no transfer right after a transfer
  `SSS_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready, "input taken while busy")

  // nothing pending after reset
  `SSS_ASSERT_RST(a_rst_empty, !out_valid && in_ready, "result pending after reset")

endmodule

bind suffixient_set_scan_core sss_checker u_check (.*);

[verif/tb.sv]
module tb import sss_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic {KIND_TRIPLE, KIND_END} in_kind_e;
  typedef enum logic {RES_MEMBER, RES_SUMMARY} res_kind_e;
  typedef enum logic [1:0] {ROW_ITEM, ROW_CFG} row_op_e;
  typedef enum logic [1:0] {WANT_MODEL, WANT_NONE, WANT_GIVEN} want_e;

  typedef struct packed {
    in_kind_e           kind;
    logic [SYM_W-1:0]   sym;
    logic [FIELD_W-1:0] lcp;
    logic [FIELD_W-1:0] sa;
  } scan_item_t;

  typedef struct packed {
    res_kind_e          rk;
    logic [FIELD_W-1:0] pos;
    logic [FIELD_W-1:0] size;
    logic [FIELD_W-1:0] runs;
    logic               last;
  } scan_result_t;

  typedef struct packed {
    row_op_e            op;
    scan_item_t         item;
    logic [FIELD_W-1:0] cfg_value;
    want_e              want;
    scan_result_t       given;
  } plan_row_t;

  localparam logic [FIELD_W-1:0] MAX40 = '1;
  localparam logic signed [LEN_W-1:0] FLOOR_TOP = {1'b0, RUN_MIN_MAX};
  localparam scan_result_t EMPTY_SUMMARY = '{RES_SUMMARY, '0, '0, 40'd1, 1'b1};
  localparam int SETTLE_CYCLES = SYM_SPAN + 16;
  localparam int STALL_LIMIT = 3000;
  localparam int PHASE_ITEMS = 55;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [FIELD_W-1:0] cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               kind = 1'b0;
  logic [SYM_W-1:0]   bwt_sym = '0;
  logic [FIELD_W-1:0] lcp = '0;
  logic [FIELD_W-1:0] sa_pos = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               result_kind;
  logic [FIELD_W-1:0] position;
  logic [FIELD_W-1:0] set_size;
  logic [FIELD_W-1:0] run_count;
  logic               last;

  suffixient_set_scan_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .bwt_sym     (bwt_sym),
    .lcp         (lcp),
    .sa_pos      (sa_pos),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_kind (result_kind),
    .position    (position),
    .set_size    (set_size),
    .run_count   (run_count),
    .last        (last)
  );

  always #4 clk = ~clk;

  // predictor state: candidate slots per symbol and stream counters
  logic signed [LEN_W-1:0] slot_len [SYM_SPAN];
  logic [FIELD_W-1:0]      slot_pos [SYM_SPAN];
  logic                    slot_live [SYM_SPAN];
  logic signed [LEN_W-1:0] lcp_floor;
  logic [SYM_W-1:0]        last_sym;
  logic [FIELD_W-1:0]      last_sa;
  logic                    in_stream;
  logic [FIELD_W-1:0]      members_out;
  logic [FIELD_W-1:0]      runs_out;
  logic [FIELD_W-1:0]      text_len = 40'd1;

  scan_result_t results_due [$];
  scan_result_t fresh [$];
  plan_row_t    plan [$];

  bit jitter = 1'b1;
  int failures = 0;
  int n_items = 0;
  int n_streams = 0;
  int n_members = 0;
  int n_summaries = 0;

  function automatic void clear_scan();
    for (int s = 0; s < SYM_SPAN; s++) begin
      slot_len[s] = LEN_NONE;
      slot_pos[s] = '0;
      slot_live[s] = 1'b0;
    end
    lcp_floor = FLOOR_TOP;
    last_sym = '0;
    last_sa = '0;
    in_stream = 1'b0;
    members_out = '0;
    runs_out = 40'd1;
  endfunction

  function automatic void post_result(res_kind_e rk, logic [FIELD_W-1:0] pos);
    scan_result_t r;
    r.rk = rk;
    r.pos = pos;
    r.size = members_out;
    r.runs = runs_out;
    r.last = 1'b0;
    fresh.insert(fresh.size(), r);
  endfunction

  // append one row to the directed plan
  function automatic void add_row(plan_row_t r);
    plan.insert(plan.size(), r);
  endfunction

  // drop every slot but slot zero that is longer than bound; live ones become set members
  function automatic void retire_slots(logic signed [LEN_W-1:0] bound);
    for (int s = 1; s < SYM_SPAN; s++) begin
      if (bound < slot_len[s]) begin
        if (slot_live[s]) begin
          members_out = members_out + 1'b1;
          post_result(RES_MEMBER, slot_pos[s]);
        end
        slot_len[s] = bound;
        slot_pos[s] = '0;
        slot_live[s] = 1'b0;
      end
    end
  endfunction

  // a position below zero clamps at zero
  function automatic void claim_slot(logic [SYM_W-1:0] sym, logic signed [LEN_W-1:0] l,
                                     logic [FIELD_W-1:0] sa);
    if (l > slot_len[sym]) begin
      slot_len[sym] = l;
      slot_pos[sym] = (sa > text_len) ? '0 : text_len - sa;
      slot_live[sym] = 1'b1;
    end
  endfunction

  // fills fresh with the results that one accepted item causes
  function automatic void predict_emissions(scan_item_t it);
    logic signed [LEN_W-1:0] l;
    l = $signed({1'b0, it.lcp});
    fresh.delete();
    if (it.kind == KIND_END) begin
      retire_slots(LEN_NONE);
      post_result(RES_SUMMARY, '0);
      clear_scan();
    end else if (!in_stream) begin
      in_stream = 1'b1;
      last_sym = it.sym;
      last_sa = it.sa;
    end else begin
      if (l < lcp_floor) lcp_floor = l;
      if (it.sym != last_sym) begin
        retire_slots(lcp_floor);
        claim_slot(last_sym, l, last_sa);
        claim_slot(it.sym, l, it.sa);
        lcp_floor = FLOOR_TOP;
        runs_out = runs_out + 1'b1;
      end
      last_sym = it.sym;
      last_sa = it.sa;
    end
    if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
  endfunction

  function automatic logic [FIELD_W-1:0] rand40();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[FIELD_W-1:0];
  endfunction

  function automatic plan_row_t triple_row(int unsigned sym, logic [FIELD_W-1:0] l,
                                           logic [FIELD_W-1:0] sa, want_e w);
    plan_row_t r;
    r = '0;
    r.op = ROW_ITEM;
    r.item.kind = KIND_TRIPLE;
    r.item.sym = sym[SYM_W-1:0];
    r.item.lcp = l;
    r.item.sa = sa;
    r.want = w;
    return r;
  endfunction

  function automatic plan_row_t end_row(want_e w);
    plan_row_t r;
    r = '0;
    r.op = ROW_ITEM;
    r.item.kind = KIND_END;
    r.want = w;
    if (w == WANT_GIVEN) r.given = EMPTY_SUMMARY;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(logic [FIELD_W-1:0] v);
    plan_row_t r;
    r = '0;
    r.op = ROW_CFG;
    r.cfg_value = v;
    return r;
  endfunction

  // one transfer on the item channel, with random lead-in gaps
  task automatic send_item(scan_item_t it, want_e w, scan_result_t given);
    @(negedge clk);
    while (jitter && $urandom_range(99) < 30) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    kind = it.kind;
    bwt_sym = it.sym;
    lcp = it.lcp;
    sa_pos = it.sa;
    do @(posedge clk); while (!in_ready);
    predict_emissions(it);
    case (w)
      WANT_MODEL: foreach (fresh[k]) results_due.insert(results_due.size(), fresh[k]);
      WANT_GIVEN: results_due.insert(results_due.size(), given);
      default: ;
    endcase
    n_items++;
    if (it.kind == KIND_END) n_streams++;
  endtask

  // hold the sender until every expected result is back and the scan has finished
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_text_length(logic [FIELD_W-1:0] v);
    settle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    text_len = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [FIELD_W-1:0] pick_sa();
    longint unsigned span;
    int unsigned roll;
    span = longint'(text_len) + 1;
    roll = $urandom_range(99);
    if (roll < 70) return FIELD_W'(rand40() % span);
    if (roll < 85) return text_len + $urandom_range(1, 8);
    return rand40();
  endfunction

  // a stream of triples over a small symbol pool; noisy ones are fully random
  task automatic feed_stream(int n, bit noisy);
    logic [SYM_W-1:0] pool [4];
    scan_item_t it;
    int width;
    width = $urandom_range(2, 4);
    foreach (pool[j]) pool[j] = SYM_W'($urandom_range(0, SYM_SPAN - 1));
    it = '0;
    it.sym = pool[0];
    for (int i = 0; i < n; i++) begin
      if (noisy) begin
        it.kind = ($urandom_range(3) == 0) ? KIND_END : KIND_TRIPLE;
        it.sym = SYM_W'($urandom_range(0, SYM_SPAN - 1));
        it.lcp = rand40();
        it.sa = rand40();
      end else begin
        it.kind = KIND_TRIPLE;
        if ($urandom_range(99) < 45) it.sym = pool[$urandom_range(0, width - 1)];
        it.lcp = ($urandom_range(99) < 90) ? 40'($urandom_range(0, 12)) : rand40();
        it.sa = pick_sa();
      end
      send_item(it, WANT_MODEL, '0);
    end
    if (!noisy) begin
      it = '0;
      it.kind = KIND_END;
      send_item(it, WANT_MODEL, '0);
    end
  endtask

  // receiver stalls
  always @(negedge clk) begin
    out_ready = !jitter || ($urandom_range(99) >= 30);
  end

  // result checker
  always @(posedge clk) begin
    scan_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $error("unexpected result: kind %0d position %0d", result_kind, position);
        failures++;
      end else begin
        want = results_due.pop_front();
        if (result_kind !== want.rk) begin
          $error("result_kind: expected %0d, got %0d", want.rk, result_kind);
          failures++;
        end
        if (position !== want.pos) begin
          $error("position: expected %0d, got %0d", want.pos, position);
          failures++;
        end
        if (set_size !== want.size) begin
          $error("set_size: expected %0d, got %0d", want.size, set_size);
          failures++;
        end
        if (run_count !== want.runs) begin
          $error("run_count: expected %0d, got %0d", want.runs, run_count);
          failures++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          failures++;
        end
        if (want.rk == RES_SUMMARY) n_summaries++;
        else n_members++;
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  // stimulus
  initial begin
    logic [FIELD_W-1:0] phase_len [4];
    int goal;

    clear_scan();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: text length left at its reset value first
    add_row(end_row(WANT_GIVEN));                // end with no triples
    add_row(end_row(WANT_GIVEN));                // and again right after
    add_row(triple_row(5, MAX40, 40'd0, WANT_NONE)); // first triple, lcp ignored
    add_row(triple_row(5, 40'd3, 40'd0, WANT_NONE)); // inside a run
    add_row(triple_row(0, 40'd2, 40'd1, WANT_MODEL)); // boundary into symbol zero
    add_row(triple_row(63, 40'd1, 40'd5, WANT_MODEL)); // sa past text length
    add_row(triple_row(63, 40'd0, 40'd1, WANT_NONE));
    add_row(triple_row(1, 40'd0, 40'd0, WANT_MODEL));
    add_row(end_row(WANT_MODEL));
    add_row(cfg_row(MAX40));
    add_row(triple_row(1, MAX40, 40'd0, WANT_NONE));
    add_row(triple_row(2, MAX40, MAX40, WANT_MODEL)); // sa equal to text length
    add_row(triple_row(1, MAX40 - 1, 40'd1, WANT_MODEL));
    add_row(triple_row(2, 40'd0, 40'h55_5555_5555, WANT_MODEL));
    add_row(triple_row(62, MAX40, 40'hAA_AAAA_AAAA, WANT_MODEL));
    add_row(end_row(WANT_MODEL));
    add_row(cfg_row(40'd1000));
    add_row(triple_row(10, 40'd0, 40'd0, WANT_NONE));
    add_row(triple_row(20, 40'd7, 40'd100, WANT_MODEL));
    add_row(triple_row(30, 40'd9, 40'd999, WANT_MODEL));
    add_row(triple_row(40, 40'd4, 40'd1000, WANT_MODEL));
    add_row(triple_row(40, 40'd8, 40'd1001, WANT_NONE));
    add_row(triple_row(10, 40'd6, 40'd3, WANT_MODEL));
    add_row(triple_row(0, 40'd2, 40'd50, WANT_MODEL));
    add_row(end_row(WANT_MODEL));
    add_row(end_row(WANT_GIVEN));

    foreach (plan[r]) begin
      if (plan[r].op == ROW_CFG) set_text_length(plan[r].cfg_value);
      else send_item(plan[r].item, plan[r].want, plan[r].given);
    end

    // random streams, one text length per phase; phase two runs without stalls
    phase_len[0] = MAX40;
    phase_len[1] = 40'd1;
    phase_len[2] = rand40();
    if (phase_len[2] == '0) phase_len[2] = 40'd1;
    phase_len[3] = 40'd64;
    for (int ph = 0; ph < 4; ph++) begin
      set_text_length(phase_len[ph]);
      jitter = (ph != 2);
      goal = n_items + PHASE_ITEMS;
      while (n_items < goal) begin
        if ($urandom_range(9) == 0)
          feed_stream($urandom_range(1, 12), 1'b1);
        else if ($urandom_range(9) == 0)
          feed_stream($urandom_range(30, 45), 1'b0);
        else
          feed_stream($urandom_range(0, 16), 1'b0);
      end
      feed_stream(0, 1'b0);
    end
    jitter = 1'b1;

    // drain
    settle();
    if (results_due.size() != 0) begin
      $error("%0d expected results never arrived", results_due.size());
      failures++;
    end

    $display("tb: %0d items in %0d streams, %0d members and %0d summaries checked",
             n_items, n_streams, n_members, n_summaries);
    $display("tb: text length at 1, 1000, 64, all ones and 0x%0h", phase_len[2]);
    if (failures == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/sss_pkg.sv
rtl/sss_cell.sv
rtl/sss_head.sv
rtl/suffixient_set_scan_core.sv
rtl/sss_checker.sv
verif/tb.sv
